### hw/rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared constants and codes for the best and second center search.
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_CENTERS   = 16;
  localparam int DEF_MAX_DIMENSION = 64;
  localparam int DEF_COORD_WIDTH   = 16;

  // Squared-distance arithmetic
  localparam int DIFF_W = 20;
  localparam int DIST_W = 2 * DIFF_W;
  localparam logic [DIFF_W-1:0] DIFF_LIMIT = '1;
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;

  // Item opcodes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_COUNT = 1'b0,
    CFG_DIMENSION    = 1'b1
  } cfg_index_t;

endpackage

`default_nettype wire

### hw/rtl/bcs_center_mem.sv
// ----------------------------------------------------------------------------
// bcs_center_mem
// Centre coordinate store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_center_mem import bcs_pkg::*; #(
  parameter int MAX_CENTERS   = DEF_MAX_CENTERS,
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
  localparam int CIW   = $clog2(MAX_CENTERS),
  localparam int DIW   = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1,
  localparam int AW    = CIW + DIW,
  localparam int DEPTH = MAX_CENTERS * (1 << DIW)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [COORD_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]          rd_addr,
  output logic [COORD_WIDTH-1:0] rd_data
);

  logic [COORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/bcs_sum_mem.sv
// ----------------------------------------------------------------------------
// bcs_sum_mem
// Running distance sums, one per centre, with per-entry valid bits.
// An entry not written since the last clear reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_sum_mem import bcs_pkg::*; #(
  parameter int MAX_CENTERS = DEF_MAX_CENTERS,
  localparam int CIW = $clog2(MAX_CENTERS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              wr_en,
  input  logic [CIW-1:0]    wr_addr,
  input  logic [DIST_W-1:0] wr_data,
  input  logic [CIW-1:0]    rd_addr,
  output logic [DIST_W-1:0] rd_data
);

  logic [DIST_W-1:0]      mem [MAX_CENTERS];
  logic [MAX_CENTERS-1:0] valid;
  logic [DIST_W-1:0]      rd_raw;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (clr) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

### hw/rtl/bcs_dist_unit.sv
// ----------------------------------------------------------------------------
// bcs_dist_unit
// Shared squared-difference unit: square, then saturating accumulate.
// Two register stages; the write-back leaves after the first.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_dist_unit import bcs_pkg::*; #(
  parameter int MAX_CENTERS = DEF_MAX_CENTERS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  localparam int CIW = $clog2(MAX_CENTERS),
  localparam int MW  = (COORD_WIDTH + 1 > DIFF_W) ? COORD_WIDTH + 1 : DIFF_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_v,
  input  logic [CIW-1:0]                in_idx,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] c,
  input  logic [DIST_W-1:0]             sum_in,
  output logic                          wb_en,
  output logic [CIW-1:0]                wb_idx,
  output logic [DIST_W-1:0]             wb_sum,
  output logic                          res_v,
  output logic [CIW-1:0]                res_idx,
  output logic [DIST_W-1:0]             res_sum,
  output logic                          busy
);

  logic [COORD_WIDTH:0] diff;
  logic [COORD_WIDTH:0] mag;
  logic [DIFF_W-1:0]    mag_n;
  logic                 over;
  logic [DIST_W-1:0]    sq;

  logic                 v2;
  logic [CIW-1:0]       idx2;
  logic [DIST_W-1:0]    sq2;
  logic                 over2;
  logic [DIST_W-1:0]    sum2;
  logic [DIST_W:0]      total;

  assign diff  = {x[COORD_WIDTH-1], x} - {c[COORD_WIDTH-1], c};
  assign mag   = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;
  assign over  = MW'(mag) > MW'(DIFF_LIMIT);
  assign mag_n = DIFF_W'(mag);

  always_comb begin
    sq = mag_n * mag_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2    <= 1'b0;
      res_v <= 1'b0;
    end else begin
      v2    <= in_v;
      res_v <= v2;
    end
    idx2    <= in_idx;
    sq2     <= sq;
    over2   <= over;
    sum2    <= sum_in;
    res_idx <= idx2;
    res_sum <= wb_sum;
  end

  // saturate when the sum would reach the ceiling or the difference is over the limit
  assign total  = {1'b0, sum2} + {1'b0, sq2};
  assign wb_sum = (over2 || total >= {1'b0, DIST_MAX}) ? DIST_MAX : total[DIST_W-1:0];
  assign wb_en  = v2;
  assign wb_idx = idx2;
  assign busy   = v2 || res_v;

endmodule

`default_nettype wire

### hw/rtl/best_and_second_center_search.sv
// ----------------------------------------------------------------------------
// best_and_second_center_search
// Load item: written as accepted, no stall. Query item: input stalls from the
// accept, through the scan of one centre a cycle through the square/accumulate
// unit, and through the drain. A query's result is offered after its last
// coordinate's drain, later while the output register is held.
// Reset: synchronous; sums read as zero, position zero, registers at maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module best_and_second_center_search import bcs_pkg::*; #(
  parameter int MAX_CENTERS   = DEF_MAX_CENTERS,
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
  localparam int CIW = $clog2(MAX_CENTERS),
  localparam int DIW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1,
  localparam int CNW = $clog2(MAX_CENTERS + 1),
  localparam int PW  = $clog2(MAX_DIMENSION + 1),
  localparam int CFW = (CNW > PW) ? CNW : PW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFW-1:0]                cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [CIW-1:0]                center_slot,
  input  logic [DIW-1:0]                coord_slot,
  input  logic signed [COORD_WIDTH-1:0] coord_value,
  input  logic [CIW-1:0]                current_center,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CIW-1:0]                chosen_center,
  output logic [CIW-1:0]                best_center,
  output logic [CIW-1:0]                second_center,
  output logic [DIST_W-1:0]             best_distance,
  output logic                          moved
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t state;

  logic [CNW-1:0] center_count;
  logic [PW-1:0]  dimension;
  logic [CNW-1:0] ncent;
  logic [PW-1:0]  ndim;

  logic [PW-1:0]                 query_position;
  logic [PW-1:0]                 pos_c;
  logic [PW-1:0]                 pos_inc;
  logic                          last;
  logic signed [COORD_WIDTH-1:0] qx;
  logic [CIW-1:0]                qcur;
  logic                          qlast;
  logic [DIW-1:0]                qpos;
  logic [CNW-1:0]                ci;
  logic                          rd_v;
  logic [CIW-1:0]                rd_idx;

  logic [DIST_W-1:0] best_d;
  logic [DIST_W-1:0] second_d;
  logic [CIW-1:0]    best_i;
  logic [CIW-1:0]    second_i;

  logic accept;
  logic load_wr;
  logic fin;

  logic [COORD_WIDTH-1:0] cen_rd;
  logic [DIST_W-1:0]      sum_rd;
  logic                   wb_en;
  logic [CIW-1:0]         wb_idx;
  logic [DIST_W-1:0]      wb_sum;
  logic                   res_v;
  logic [CIW-1:0]         res_idx;
  logic [DIST_W-1:0]      res_sum;
  logic                   dist_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_count <= CNW'(MAX_CENTERS);
      dimension    <= PW'(MAX_DIMENSION);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CENTER_COUNT: center_count <= cfg_data[CNW-1:0];
        CFG_DIMENSION:    dimension    <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  assign ncent = (center_count == '0) ? CNW'(1) :
                 (center_count > CNW'(MAX_CENTERS)) ? CNW'(MAX_CENTERS) : center_count;
  assign ndim  = (dimension == '0) ? PW'(1) :
                 (dimension > PW'(MAX_DIMENSION)) ? PW'(MAX_DIMENSION) : dimension;

  assign pos_c   = (query_position >= PW'(MAX_DIMENSION)) ? PW'(MAX_DIMENSION - 1)
                                                          : query_position;
  assign pos_inc = pos_c + PW'(1);
  assign last    = pos_inc >= ndim;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_wr  = accept && (opcode == OP_LOAD) &&
                    (int'(center_slot) < MAX_CENTERS) && (int'(coord_slot) < MAX_DIMENSION);

  // Query end: pipeline empty and the output register free
  assign fin = (state == S_DRAIN) && !rd_v && !dist_busy && qlast &&
               (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      query_position <= '0;
      rd_v           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      rd_v <= (state == S_RUN);
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && opcode == OP_QUERY) begin
            qx             <= coord_value;
            qcur           <= current_center;
            qlast          <= last;
            qpos           <= pos_c[DIW-1:0];
            query_position <= last ? '0 : pos_inc;
            ci             <= '0;
            best_d         <= DIST_MAX;
            second_d       <= DIST_MAX;
            best_i         <= '0;
            second_i       <= '0;
            state          <= S_RUN;
          end
        end
        S_RUN: begin
          rd_idx <= ci[CIW-1:0];
          ci     <= ci + CNW'(1);
          if (ci + CNW'(1) == ncent) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // hold until the last write-back and scan step have landed
          if (!rd_v && !dist_busy) begin
            if (!qlast) begin
              state <= S_IDLE;
            end else if (fin) begin
              best_center   <= best_i;
              second_center <= second_i;
              best_distance <= best_d;
              moved         <= (best_i != qcur);
              chosen_center <= (best_i != qcur) ? best_i : second_i;
              state         <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // Scan in index order; strict compare keeps the first of equal sums
      if (res_v) begin
        priority if (res_sum < best_d) begin
          second_d <= best_d;
          second_i <= best_i;
          best_d   <= res_sum;
          best_i   <= res_idx;
        end else if (res_sum < second_d) begin
          second_d <= res_sum;
          second_i <= res_idx;
        end
      end
    end
  end

  bcs_center_mem #(
    .MAX_CENTERS  (MAX_CENTERS),
    .MAX_DIMENSION(MAX_DIMENSION),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_center_mem (
    .clk    (clk),
    .wr_en  (load_wr),
    .wr_addr({center_slot, coord_slot}),
    .wr_data(coord_value),
    .rd_addr({ci[CIW-1:0], qpos}),
    .rd_data(cen_rd)
  );

  bcs_sum_mem #(
    .MAX_CENTERS(MAX_CENTERS)
  ) u_sum_mem (
    .clk    (clk),
    .rst    (rst),
    .clr    (fin),
    .wr_en  (wb_en),
    .wr_addr(wb_idx),
    .wr_data(wb_sum),
    .rd_addr(ci[CIW-1:0]),
    .rd_data(sum_rd)
  );

  bcs_dist_unit #(
    .MAX_CENTERS(MAX_CENTERS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dist_unit (
    .clk    (clk),
    .rst    (rst),
    .in_v   (rd_v),
    .in_idx (rd_idx),
    .x      (qx),
    .c      (cen_rd),
    .sum_in (sum_rd),
    .wb_en  (wb_en),
    .wb_idx (wb_idx),
    .wb_sum (wb_sum),
    .res_v  (res_v),
    .res_idx(res_idx),
    .res_sum(res_sum),
    .busy   (dist_busy)
  );

endmodule

`default_nettype wire

### hw/rtl/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks for the best and second center search, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_checker import bcs_pkg::*; #(
  parameter int CIW = $clog2(DEF_MAX_CENTERS)
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           opcode,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire logic [CIW-1:0] chosen_center,
  input wire logic [CIW-1:0] best_center,
  input wire logic [CIW-1:0] second_center,
  input wire logic           moved
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_center) && $stable(best_center))
    else $error("stalled result changed");

  a_choice: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (moved ? (chosen_center == best_center)
                         : (chosen_center == second_center)))
    else $error("chosen centre disagrees with moved flag");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_QUERY |=> in_stall)
    else $error("query item did not occupy the search engine");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load item produced a result");

endmodule

bind best_and_second_center_search bcs_checker #(
  .CIW($clog2(MAX_CENTERS))
) u_bcs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .opcode       (opcode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .chosen_center(chosen_center),
  .best_center  (best_center),
  .second_center(second_center),
  .moved        (moved)
);

`default_nettype wire

### verif/bcs_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_result_checker
// Watches the register port and both channels of the centre search. Keeps its
// own centre table and running distances, predicts the result of every query
// that ends, and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module bcs_result_checker import bcs_pkg::*; #(
  parameter int NC = DEF_MAX_CENTERS,
  parameter int ND = DEF_MAX_DIMENSION,
  parameter int CW = DEF_COORD_WIDTH,
  localparam int CIW = $clog2(NC),
  localparam int DIW = (ND > 1) ? $clog2(ND) : 1,
  localparam int CNW = $clog2(NC + 1),
  localparam int PW  = $clog2(ND + 1),
  localparam int CFW = (CNW > PW) ? CNW : PW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFW-1:0]       cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 opcode,
  input  logic [CIW-1:0]       center_slot,
  input  logic [DIW-1:0]       coord_slot,
  input  logic signed [CW-1:0] coord_value,
  input  logic [CIW-1:0]       current_center,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CIW-1:0]       chosen_center,
  input  logic [CIW-1:0]       best_center,
  input  logic [CIW-1:0]       second_center,
  input  logic [DIST_W-1:0]    best_distance,
  input  logic                 moved,
  output int                   mismatch_count,
  output int                   pending_results
);

  typedef struct packed {
    logic [CIW-1:0]    chosen;
    logic [CIW-1:0]    best;
    logic [CIW-1:0]    second;
    logic [DIST_W-1:0] distance;
    logic              moved;
  } search_result_t;

  search_result_t       awaited_results[$];
  logic signed [CW-1:0] centre_table[NC][ND];
  logic [DIST_W-1:0]    running_dist[NC];
  int unsigned          position;
  logic [CNW-1:0]       count_reg;
  logic [PW-1:0]        dim_reg;
  int                   errors = 0;
  int                   waiting = 0;

  assign mismatch_count  = errors;
  assign pending_results = waiting;

  function automatic int unsigned live_centres();
    if (count_reg == 0) return 1;
    if (count_reg > NC) return NC;
    return count_reg;
  endfunction

  function automatic int unsigned live_dimension();
    if (dim_reg == 0) return 1;
    if (dim_reg > ND) return ND;
    return dim_reg;
  endfunction

  // Squared difference added to a running sum, pinned at the top of the range
  function automatic logic [DIST_W-1:0] add_square(logic [DIST_W-1:0] sum,
                                                   logic signed [CW-1:0] a,
                                                   logic signed [CW-1:0] b);
    longint      diff;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] room;
    diff = longint'(a) - longint'(b);
    mag  = (diff < 0) ? -diff : diff;
    if (mag > DIFF_LIMIT) return DIST_MAX;
    sq   = mag * mag;
    room = DIST_MAX - sum;
    if (sq >= room) return DIST_MAX;
    return sum + sq[DIST_W-1:0];
  endfunction

  function automatic void compare_field(string field, logic [DIST_W-1:0] want,
                                        logic [DIST_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    search_result_t got;
    search_result_t want;
    int unsigned    nc;
    int unsigned    nd;
    int unsigned    col;
    int unsigned    best_i;
    int unsigned    second_i;
    logic [DIST_W-1:0] best_d;
    logic [DIST_W-1:0] second_d;
    if (rst) begin
      awaited_results.delete();
      foreach (running_dist[i]) running_dist[i] = '0;
      foreach (centre_table[i, j]) centre_table[i][j] = '0;
      position  = 0;
      count_reg = CNW'(NC);
      dim_reg   = PW'(ND);
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_CENTER_COUNT: count_reg = cfg_data[CNW-1:0];
          CFG_DIMENSION:    dim_reg   = cfg_data[PW-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (opcode == OP_LOAD) begin
          if (center_slot < NC && coord_slot < ND)
            centre_table[center_slot][coord_slot] = coord_value;
        end else begin
          nc  = live_centres();
          nd  = live_dimension();
          col = (position >= ND) ? ND - 1 : position;
          for (int i = 0; i < nc; i++)
            running_dist[i] = add_square(running_dist[i], coord_value,
                                         centre_table[i][col]);
          if (col + 1 < nd) begin
            position = col + 1;
          end else begin
            // strict less-than: the first of equal distances keeps its place
            best_d   = DIST_MAX;
            second_d = DIST_MAX;
            best_i   = 0;
            second_i = 0;
            for (int i = 0; i < nc; i++) begin
              if (running_dist[i] < best_d) begin
                second_d = best_d;
                second_i = best_i;
                best_d   = running_dist[i];
                best_i   = i;
              end else if (running_dist[i] < second_d) begin
                second_d = running_dist[i];
                second_i = i;
              end
            end
            want.best     = CIW'(best_i);
            want.second   = CIW'(second_i);
            want.distance = best_d;
            want.moved    = (best_i != current_center);
            want.chosen   = want.moved ? want.best : want.second;
            awaited_results.insert(awaited_results.size(), want);
            foreach (running_dist[i]) running_dist[i] = '0;
            position = 0;
          end
        end
      end

      if (out_valid && !out_stall) begin
        got = '{chosen_center, best_center, second_center, best_distance, moved};
        if (awaited_results.size() == 0) begin
          $error("result item with no prediction waiting");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("chosen_center", want.chosen, got.chosen);
          compare_field("best_center", want.best, got.best);
          compare_field("second_center", want.second, got.second);
          compare_field("best_distance", want.distance, got.distance);
          compare_field("moved", want.moved, got.moved);
        end
      end
    end
    waiting = awaited_results.size();
  end

endmodule

### verif/tb_best_and_second_center_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_and_second_center_search
// Fills centre tables and streams queries through the centre search with
// bursty input, a stalling receiver and register changes between and within
// queries. The result checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_best_and_second_center_search;
  import bcs_pkg::*;

  localparam int NC  = DEF_MAX_CENTERS;
  localparam int ND  = DEF_MAX_DIMENSION;
  localparam int CW  = DEF_COORD_WIDTH;
  localparam int CIW = $clog2(NC);
  localparam int DIW = (ND > 1) ? $clog2(ND) : 1;
  localparam int CNW = $clog2(NC + 1);
  localparam int PW  = $clog2(ND + 1);
  localparam int CFW = (CNW > PW) ? CNW : PW;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = NC + 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 500;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFW-1:0]       cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 opcode = OP_LOAD;
  logic [CIW-1:0]       center_slot = '0;
  logic [DIW-1:0]       coord_slot = '0;
  logic signed [CW-1:0] coord_value = '0;
  logic [CIW-1:0]       current_center = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CIW-1:0]       chosen_center;
  logic [CIW-1:0]       best_center;
  logic [CIW-1:0]       second_center;
  logic [DIST_W-1:0]    best_distance;
  logic                 moved;
  int                   mismatch_count;
  int                   pending_results;

  // sender bookkeeping
  int          burst_left = 0;
  bit          steady = 1'b0;
  bit          hold_off = 1'b0;
  int          q_pos = 0;
  int          count_raw = NC;
  int          dim_raw = ND;
  int          items_sent = 0;
  bit          loaded[NC][ND];
  int unsigned cycle_count = 0;

  best_and_second_center_search DUT (.*);

  bcs_result_checker result_check (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_best_and_second_center_search failed");
      $finish;
    end
  end

  // Receiver: its own stall pattern, changed every so often, plus one long hold
  initial begin : receiver
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 150);
      for (int tick = 0; tick < span; tick++) begin
        @(negedge clk);
        if (hold_off) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off = 1'b0;
        end
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 3) == 0);
          2:       out_stall = ($urandom_range(0, 1) == 1);
          default: out_stall = ((tick % 5) < 2);
        endcase
      end
    end
  end

  function automatic int eff_centers();
    if (count_raw == 0) return 1;
    if (count_raw > NC) return NC;
    return count_raw;
  endfunction

  function automatic int eff_dim();
    if (dim_raw == 0) return 1;
    if (dim_raw > ND) return ND;
    return dim_raw;
  endfunction

  // Extremes and a coarse grid often, so that ties and exact hits turn up
  function automatic logic signed [CW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return CW'((int'($urandom_range(0, 2)) - 1) * 256);
      3:       return CW'(int'($urandom_range(0, 1023)) - 512);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [CIW-1:0] pick_current();
    if ($urandom_range(0, 3) == 0) return CIW'($urandom_range(0, NC - 1));
    return CIW'($urandom_range(0, eff_centers() - 1));
  endfunction

  task automatic send_item(opcode_t op, logic [CIW-1:0] cslot, logic [DIW-1:0] kslot,
                           logic signed [CW-1:0] value, logic [CIW-1:0] cur);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       = 1'b1;
    opcode         = op;
    center_slot    = cslot;
    coord_slot     = kslot;
    coord_value    = value;
    current_center = cur;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_load(int c, int k, logic signed [CW-1:0] value);
    send_item(OP_LOAD, CIW'(c), DIW'(k), value, CIW'($urandom));
    loaded[c][k] = 1'b1;
  endtask

  task automatic send_query(logic signed [CW-1:0] value, logic [CIW-1:0] cur);
    send_item(OP_QUERY, CIW'($urandom), DIW'($urandom), value, cur);
    if (q_pos + 1 >= eff_dim()) q_pos = 0;
    else q_pos++;
  endtask

  // Load every entry the next query items can read, including the column of
  // a query that is already past a shrunken dimension
  task automatic fill_table();
    int cols;
    cols = (q_pos + 1 > eff_dim()) ? q_pos + 1 : eff_dim();
    for (int c = 0; c < eff_centers(); c++)
      for (int k = 0; k < cols; k++)
        if (!loaded[c][k]) send_load(c, k, pick_value());
  endtask

  // Hold the input until every result is in and the block has drained
  task automatic wait_idle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = CFW'(value);
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == CFG_CENTER_COUNT) count_raw = value;
    else dim_raw = value;
  endtask

  initial begin : stimulus
    int stop_at;
    int new_count;
    int new_dim;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait_idle();
    write_reg(CFG_CENTER_COUNT, 3);
    write_reg(CFG_DIMENSION, 2);
    send_load(0, 0, COORD_MAX);
    send_load(0, 1, COORD_MIN);
    send_load(1, 0, '0);
    send_load(1, 1, '0);
    send_load(2, 0, '0);
    send_load(2, 1, '0);
    // centres 1 and 2 tie; the current one is the best, so fall to the second
    send_query('0, CIW'(1));
    send_query('0, CIW'(1));
    // current centre beyond the active ones
    send_query(COORD_MIN, CIW'(15));
    send_query(COORD_MAX, CIW'(15));
    send_query(COORD_MAX, CIW'(0));
    send_query(COORD_MIN, CIW'(0));

    // shrink the dimension part-way through a query
    send_query(COORD_MIN, CIW'(0));
    wait_idle();
    write_reg(CFG_DIMENSION, 1);
    send_query(COORD_MAX, CIW'(2));

    // single centre: no second best
    wait_idle();
    write_reg(CFG_CENTER_COUNT, 0);
    send_query(CW'(256), CIW'(0));
    send_query(COORD_MIN, CIW'(7));

    // centres that join part-way through a query
    wait_idle();
    write_reg(CFG_CENTER_COUNT, 2);
    write_reg(CFG_DIMENSION, 2);
    send_query(pick_value(), CIW'(1));
    wait_idle();
    write_reg(CFG_CENTER_COUNT, 4);
    fill_table();
    send_query(pick_value(), CIW'(3));

    items_sent = 0;
    for (int phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 11))
        0:       new_count = 0;
        1:       new_count = $urandom_range(NC + 1, 31);
        default: new_count = $urandom_range(1, NC);
      endcase
      case ($urandom_range(0, 11))
        0:       new_dim = 0;
        1:       new_dim = $urandom_range(ND + 1, 127);
        2, 3:    new_dim = $urandom_range(9, ND);
        default: new_dim = $urandom_range(1, 8);
      endcase
      // the first phase floods the stalled receiver with one-item queries
      if (phase == 0) begin
        new_count = $urandom_range(2, NC);
        new_dim   = 1;
      end
      if (new_dim > 8 && new_count > 4) new_count = $urandom_range(1, 4);
      write_reg(CFG_CENTER_COUNT, new_count);
      write_reg(CFG_DIMENSION, new_dim);
      fill_table();
      if (phase == 0) hold_off = 1'b1;
      stop_at = items_sent + ((phase == 0) ? 60 : $urandom_range(20, 60));
      while (items_sent < stop_at) begin
        if (phase != 0 && $urandom_range(0, 19) == 0) begin
          // retune a register, often in the middle of a query
          wait_idle();
          if ($urandom_range(0, 1) == 1)
            write_reg(CFG_CENTER_COUNT, (eff_dim() > 8) ? $urandom_range(1, 4)
                                                        : $urandom_range(1, NC));
          else
            write_reg(CFG_DIMENSION, $urandom_range(1, 8));
          fill_table();
        end else if ($urandom_range(0, 6) == 0) begin
          send_load($urandom_range(0, NC - 1), $urandom_range(0, ND - 1), pick_value());
        end else begin
          send_query(pick_value(), pick_current());
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("tb_best_and_second_center_search passed");
    else
      $display("tb_best_and_second_center_search failed");
    $finish;
  end

endmodule
